// File: rtl/mdc_pkg.sv
// Shared types and codes for the MSI directory controller.
// Used by mdc_ctrl, mdc_datapath and msi_directory_controller; depends on nothing.
`default_nettype none

package mdc_pkg;

   // Request modes
   localparam logic [1:0] MODE_READ_MISS  = 2'd0;
   localparam logic [1:0] MODE_WRITE_MISS = 2'd1;
   localparam logic [1:0] MODE_INVALIDATE = 2'd2;

   // Directory entry states
   localparam logic [1:0] DIR_UNCACHED  = 2'd0;
   localparam logic [1:0] DIR_SHARED    = 2'd1;
   localparam logic [1:0] DIR_EXCLUSIVE = 2'd2;

   localparam int unsigned RSP_PROCS = 4;

   typedef struct packed {
      logic clear_en;   // write a zero entry at the sweep counter
      logic capture;    // latch the request, read its entry
      logic update;     // apply the transition, write back, present the result
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done; // sweep counter is at the last entry
   } dp_status_type;

   function automatic logic [1:0] lowest_set(input logic [RSP_PROCS-1:0] vec);
      logic [1:0] pos;
      if (vec[0]) begin
         pos = 2'd0;
      end else if (vec[1]) begin
         pos = 2'd1;
      end else if (vec[2]) begin
         pos = 2'd2;
      end else if (vec[3]) begin
         pos = 2'd3;
      end else begin
         pos = 2'd0;
      end
      return pos;
   endfunction

endpackage

`default_nettype wire

// File: rtl/mdc_ctrl.sv
// Sequencer of the MSI directory controller: clearing sweep, capture, update.
// Depends on mdc_pkg for the command and status structs.
`default_nettype none

module mdc_ctrl (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  start,
   input  wire mdc_pkg::dp_status_type status,
   output logic                       busy,
   output mdc_pkg::ctrl_cmd_type      cmd
);
   import mdc_pkg::*;

   typedef enum logic [2:0] {
      ST_CLEAR  = 3'b001,
      ST_IDLE   = 3'b010,
      ST_UPDATE = 3'b100
   } fsm_state_type;

   fsm_state_type state_ff;
   fsm_state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_en = 1'b1;
            if (status.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (start) begin
               cmd.capture = 1'b1;
               state_in    = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_IDLE;
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: rtl/mdc_datapath.sv
// Datapath of the MSI directory controller: directory memory, request
// registers, transition logic and result registers. Depends on mdc_pkg.
`default_nettype none

module mdc_datapath #(
   parameter int unsigned NUM_BLOCKS  = 1024,
   parameter int unsigned OFFSET_BITS = 6
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire mdc_pkg::ctrl_cmd_type  cmd,
   output mdc_pkg::dp_status_type      status,
   input  wire logic [1:0]             req_mode,
   input  wire logic [15:0]            req_address,
   input  wire logic [1:0]             req_requester,
   output logic                        rsp_valid,
   output logic                        rsp_from_owner,
   output logic [1:0]                  rsp_owner_id,
   output logic                        rsp_do_write_back,
   output logic [3:0]                  rsp_invalidate_mask,
   output logic [1:0]                  rsp_next_state,
   output logic [3:0]                  rsp_sharers_after,
   output logic                        rsp_range_error
);
   import mdc_pkg::*;

   localparam int unsigned IDX_W   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int unsigned ENTRY_W = 2 + RSP_PROCS;

   logic [ENTRY_W-1:0] mem [NUM_BLOCKS];

   logic [IDX_W-1:0]     clr_cnt_ff;
   logic [IDX_W-1:0]     idx_ff;
   logic [1:0]           mode_ff;
   logic [1:0]           requester_ff;
   logic                 err_ff;
   logic [ENTRY_W-1:0]   rd_data_ff;

   logic                 rsp_valid_ff;
   logic                 from_owner_ff;
   logic [1:0]           owner_id_ff;
   logic                 write_back_ff;
   logic [3:0]           inv_mask_ff;
   logic [1:0]           next_state_ff;
   logic [3:0]           sharers_ff;
   logic                 range_error_ff;

   logic [31:0]          idx_wide;
   logic                 req_err;
   logic [1:0]           cur_st;
   logic [RSP_PROCS-1:0] cur_vec;
   logic [RSP_PROCS-1:0] rbit;
   logic [RSP_PROCS-1:0] nxt_vec;
   logic [RSP_PROCS-1:0] inv_vec;
   logic [1:0]           nxt_st;
   logic                 own_supply;
   logic                 wr_en;
   logic [IDX_W-1:0]     wr_addr;
   logic [ENTRY_W-1:0]   wr_data;

   assign idx_wide = 32'(req_address >> OFFSET_BITS);
   assign req_err  = (idx_wide >= 32'(NUM_BLOCKS)) ||
                     (32'(req_requester) >= 32'(RSP_PROCS));

   assign status.clear_done = (clr_cnt_ff == IDX_W'(NUM_BLOCKS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_cnt_ff <= '0;
      end else if (cmd.clear_en && !status.clear_done) begin
         clr_cnt_ff <= clr_cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         idx_ff       <= idx_wide[IDX_W-1:0];
         mode_ff      <= req_mode;
         requester_ff <= req_requester;
         err_ff       <= req_err;
      end
   end

   // Directory memory: one read at capture, one write at update or during the sweep
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         rd_data_ff <= mem[idx_wide[IDX_W-1:0]];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   assign cur_st  = rd_data_ff[ENTRY_W-1 -: 2];
   assign cur_vec = rd_data_ff[RSP_PROCS-1:0];
   assign rbit    = RSP_PROCS'(1) << requester_ff;

   assign own_supply = (mode_ff == MODE_READ_MISS || mode_ff == MODE_WRITE_MISS) &&
                       (cur_st == DIR_EXCLUSIVE) && (cur_vec != '0);

   always_comb begin
      nxt_vec = cur_vec;
      nxt_st  = cur_st;
      inv_vec = '0;
      case (mode_ff)
         MODE_READ_MISS: begin
            nxt_vec = cur_vec | rbit;
            nxt_st  = DIR_SHARED;
         end
         MODE_WRITE_MISS: begin
            inv_vec = cur_vec;
            nxt_vec = rbit;
            nxt_st  = DIR_EXCLUSIVE;
         end
         MODE_INVALIDATE: begin
            inv_vec = cur_vec;
            nxt_vec = '0;
            nxt_st  = DIR_UNCACHED;
         end
         default: begin
            nxt_vec = cur_vec;
            nxt_st  = cur_st;
         end
      endcase
   end

   always_comb begin
      if (cmd.clear_en) begin
         wr_en   = 1'b1;
         wr_addr = clr_cnt_ff;
         wr_data = '0;
      end else begin
         wr_en   = cmd.update && !err_ff;
         wr_addr = idx_ff;
         wr_data = {nxt_st, nxt_vec};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         if (err_ff) begin
            from_owner_ff  <= 1'b0;
            owner_id_ff    <= 2'd0;
            write_back_ff  <= 1'b0;
            inv_mask_ff    <= 4'd0;
            next_state_ff  <= DIR_UNCACHED;
            sharers_ff     <= 4'd0;
            range_error_ff <= 1'b1;
         end else begin
            from_owner_ff  <= own_supply;
            owner_id_ff    <= own_supply ? lowest_set(cur_vec) : 2'd0;
            write_back_ff  <= own_supply;
            inv_mask_ff    <= inv_vec;
            next_state_ff  <= nxt_st;
            sharers_ff     <= nxt_vec;
            range_error_ff <= 1'b0;
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_from_owner      = from_owner_ff;
   assign rsp_owner_id        = owner_id_ff;
   assign rsp_do_write_back   = write_back_ff;
   assign rsp_invalidate_mask = inv_mask_ff;
   assign rsp_next_state      = next_state_ff;
   assign rsp_sharers_after   = sharers_ff;
   assign rsp_range_error     = range_error_ff;

endmodule

`default_nettype wire

// File: rtl/msi_directory_controller.sv
// MSI directory controller top level: sequencer plus datapath.
// Depends on mdc_pkg, mdc_ctrl and mdc_datapath.
//
// Usage:
//   Request channel: drive req_mode, req_address and req_requester with start
//   high; the request is taken at a clock edge where start is high and busy
//   is low. The entry index is req_address >> OFFSET_BITS.
//   Result channel: exactly one result per request, shown on the rsp_ ports
//   for one cycle while rsp_valid is high. The receiver cannot stall; the
//   result must be taken in that cycle.
//   Sequence: the accepting edge registers the request and its directory
//   entry; the update then writes the entry back and registers the result,
//   raising rsp_valid. Busy stays high until the update is done, so a new
//   request is taken only after the previous one is through its update.
//   Reset: synchronous, active high. After reset the block sweeps the
//   directory memory to uncached with empty sharer vectors, one entry per
//   cycle, all NUM_BLOCKS entries, holding busy high; requests are taken after.
//   A request with an address beyond the directory or a requester beyond
//   the processor count leaves the directory untouched and reports
//   rsp_range_error.
`default_nettype none

module msi_directory_controller #(
   parameter int unsigned NUM_BLOCKS  = 1024,
   parameter int unsigned OFFSET_BITS = 6
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [1:0]  req_mode,
   input  wire logic [15:0] req_address,
   input  wire logic [1:0]  req_requester,
   output logic             rsp_valid,
   output logic             rsp_from_owner,
   output logic [1:0]       rsp_owner_id,
   output logic             rsp_do_write_back,
   output logic [3:0]       rsp_invalidate_mask,
   output logic [1:0]       rsp_next_state,
   output logic [3:0]       rsp_sharers_after,
   output logic             rsp_range_error
);
   import mdc_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;

   mdc_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .busy   (busy),
      .cmd    (cmd)
   );

   mdc_datapath #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_mode            (req_mode),
      .req_address         (req_address),
      .req_requester       (req_requester),
      .rsp_valid           (rsp_valid),
      .rsp_from_owner      (rsp_from_owner),
      .rsp_owner_id        (rsp_owner_id),
      .rsp_do_write_back   (rsp_do_write_back),
      .rsp_invalidate_mask (rsp_invalidate_mask),
      .rsp_next_state      (rsp_next_state),
      .rsp_sharers_after   (rsp_sharers_after),
      .rsp_range_error     (rsp_range_error)
   );

`ifndef SYNTHESIS
   // Every accepted request gets its result on rsp_valid
   a_rsp_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##2 rsp_valid)
      else $error("result missing two cycles after accept");

   // No second request is taken while one is in flight
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("request accepted while previous one in flight");

   // An exclusive entry always has exactly one sharer
   a_exclusive_single: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_range_error && rsp_next_state == DIR_EXCLUSIVE)
         |-> $onehot(rsp_sharers_after))
      else $error("exclusive entry without a single owner");
`endif

endmodule

`default_nettype wire

// File: test/tb_msi_directory_controller.sv
// Testbench for msi_directory_controller: directed coherence scenarios, then random traffic,
// checked against an in-bench directory predictor that tracks every entry's state and sharers.
// Depends on mdc_pkg and the msi_directory_controller RTL.
module tb_msi_directory_controller;
   timeunit 1ns;
   timeprecision 1ps;

   import mdc_pkg::*;

   localparam int unsigned NUM_BLOCKS     = 1024;
   localparam int unsigned OFFSET_BITS    = 6;
   localparam int unsigned WATCHDOG_LIMIT = 5000;
   localparam int unsigned RANDOM_ITEMS   = 2000;
   localparam logic [1:0]  MODE_UNUSED    = 2'd3;

   typedef struct packed {
      logic       from_owner;
      logic [1:0] owner_id;
      logic       do_write_back;
      logic [3:0] invalidate_mask;
      logic [1:0] next_state;
      logic [3:0] sharers_after;
      logic       range_error;
   } dir_outcome_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [1:0]  req_mode;
   logic [15:0] req_address;
   logic [1:0]  req_requester;
   logic        rsp_valid;
   logic        rsp_from_owner;
   logic [1:0]  rsp_owner_id;
   logic        rsp_do_write_back;
   logic [3:0]  rsp_invalidate_mask;
   logic [1:0]  rsp_next_state;
   logic [3:0]  rsp_sharers_after;
   logic        rsp_range_error;

   logic [1:0]      dir_state   [NUM_BLOCKS];
   logic [3:0]      dir_sharers [NUM_BLOCKS];
   dir_outcome_type directory_outcomes[$];
   int unsigned     fault_count;
   int unsigned     stall_cycles;
   bit              idle_on;

   msi_directory_controller #(
      .NUM_BLOCKS  (NUM_BLOCKS),
      .OFFSET_BITS (OFFSET_BITS)
   ) dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_mode            (req_mode),
      .req_address         (req_address),
      .req_requester       (req_requester),
      .rsp_valid           (rsp_valid),
      .rsp_from_owner      (rsp_from_owner),
      .rsp_owner_id        (rsp_owner_id),
      .rsp_do_write_back   (rsp_do_write_back),
      .rsp_invalidate_mask (rsp_invalidate_mask),
      .rsp_next_state      (rsp_next_state),
      .rsp_sharers_after   (rsp_sharers_after),
      .rsp_range_error     (rsp_range_error)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Apply one request to the directory copy and return what the block must report.
   function automatic dir_outcome_type resolve_request(input logic [1:0] mode,
                                                       input logic [15:0] addr,
                                                       input logic [1:0] requester);
      dir_outcome_type o;
      int unsigned     idx;
      logic [1:0]      st;
      logic [3:0]      vec;
      o = '0;
      idx = 32'(addr >> OFFSET_BITS);
      if (idx >= NUM_BLOCKS || requester >= RSP_PROCS) begin
         o.range_error = 1'b1;
         return o;
      end
      st = dir_state[idx];
      vec = dir_sharers[idx];
      if ((mode == MODE_READ_MISS || mode == MODE_WRITE_MISS) && st == DIR_EXCLUSIVE
          && vec != 4'd0) begin
         o.from_owner = 1'b1;
         o.do_write_back = 1'b1;
         // scan downward so the lowest set bit wins
         for (int i = 3; i >= 0; i--) begin
            if (vec[i]) o.owner_id = 2'(i);
         end
      end
      case (mode)
         MODE_READ_MISS: begin
            vec = vec | (4'd1 << requester);
            st = DIR_SHARED;
         end
         MODE_WRITE_MISS: begin
            o.invalidate_mask = vec;
            vec = 4'd1 << requester;
            st = DIR_EXCLUSIVE;
         end
         MODE_INVALIDATE: begin
            o.invalidate_mask = vec;
            vec = 4'd0;
            st = DIR_UNCACHED;
         end
         default: ;
      endcase
      dir_state[idx] = st;
      dir_sharers[idx] = vec;
      o.next_state = st;
      o.sharers_after = vec;
      return o;
   endfunction

   function automatic logic [15:0] blk_addr(input int unsigned blk, input int unsigned offset);
      return 16'((blk << OFFSET_BITS) | (offset & ((1 << OFFSET_BITS) - 1)));
   endfunction

   // Hold the request until the block takes it; called and returning at a falling edge.
   task automatic send_request(input logic [1:0] mode, input logic [15:0] addr,
                               input logic [1:0] requester);
      start = 1'b1;
      req_mode = mode;
      req_address = addr;
      req_requester = requester;
      @(posedge clock);
      while (busy) @(posedge clock);
      directory_outcomes.push_back(resolve_request(mode, addr, requester));
      @(negedge clock);
      if (idle_on && $urandom_range(0, 99) < 20) begin
         start = 1'b0;
         req_mode = 2'($urandom);
         req_address = 16'($urandom);
         req_requester = 2'($urandom);
         repeat ($urandom_range(1, 6)) @(negedge clock);
      end
   endtask

   task automatic test_read_sharing();
      send_request(MODE_READ_MISS, blk_addr(0, 0), 2'd0);
      send_request(MODE_READ_MISS, blk_addr(0, 5), 2'd1);
      send_request(MODE_READ_MISS, blk_addr(0, 63), 2'd3);
      send_request(MODE_READ_MISS, blk_addr(0, 1), 2'd3);
   endtask

   task automatic test_write_ownership();
      // shared -> exclusive, then owner hand-offs through read and write misses
      send_request(MODE_WRITE_MISS, blk_addr(0, 8), 2'd2);
      send_request(MODE_READ_MISS, blk_addr(0, 9), 2'd1);
      send_request(MODE_WRITE_MISS, blk_addr(0, 2), 2'd0);
      send_request(MODE_WRITE_MISS, blk_addr(0, 3), 2'd3);
      send_request(MODE_WRITE_MISS, blk_addr(0, 4), 2'd3);
      send_request(MODE_WRITE_MISS, blk_addr(5, 0), 2'd1);
   endtask

   task automatic test_invalidate();
      send_request(MODE_INVALIDATE, blk_addr(0, 0), 2'd1);
      send_request(MODE_INVALIDATE, blk_addr(0, 0), 2'd2);
      send_request(MODE_READ_MISS, blk_addr(0, 0), 2'd2);
      send_request(MODE_READ_MISS, blk_addr(0, 0), 2'd0);
      send_request(MODE_INVALIDATE, blk_addr(0, 7), 2'd3);
   endtask

   task automatic test_unused_mode();
      send_request(MODE_UNUSED, blk_addr(5, 12), 2'd0);
      send_request(MODE_UNUSED, blk_addr(0, 0), 2'd3);
   endtask

   task automatic test_address_extremes();
      send_request(MODE_READ_MISS, 16'hFFFF, 2'd3);
      send_request(MODE_WRITE_MISS, 16'hFFC0, 2'd0);
      send_request(MODE_READ_MISS, 16'h0040, 2'd2);
      send_request(MODE_INVALIDATE, 16'h0000, 2'd0);
   endtask

   task automatic test_random_traffic();
      int unsigned hot_blocks[6];
      int unsigned pick;
      logic [1:0]  mode;
      logic [15:0] addr;
      hot_blocks = '{0, 1, 2, 511, 1022, 1023};
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         // a long stretch with back-to-back requests
         idle_on = !(n >= 800 && n < 1200);
         pick = $urandom_range(0, 99);
         if (pick < 40) mode = MODE_READ_MISS;
         else if (pick < 70) mode = MODE_WRITE_MISS;
         else if (pick < 90) mode = MODE_INVALIDATE;
         else mode = MODE_UNUSED;
         // keep most traffic on a few blocks so entries cycle through every state
         if ($urandom_range(0, 99) < 85)
            addr = blk_addr(hot_blocks[$urandom_range(0, 5)], $urandom);
         else
            addr = 16'($urandom);
         send_request(mode, addr, 2'($urandom));
      end
      idle_on = 1'b1;
   endtask

   always @(posedge clock) begin : check_results
      dir_outcome_type want;
      dir_outcome_type seen;
      if (!reset && rsp_valid) begin
         seen = {rsp_from_owner, rsp_owner_id, rsp_do_write_back, rsp_invalidate_mask,
                 rsp_next_state, rsp_sharers_after, rsp_range_error};
         if (directory_outcomes.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: result with no request outstanding", $realtime);
         end else begin
            want = directory_outcomes.pop_front();
            if (want.from_owner !== seen.from_owner || want.owner_id !== seen.owner_id
                || want.do_write_back !== seen.do_write_back
                || want.invalidate_mask !== seen.invalidate_mask
                || want.next_state !== seen.next_state
                || want.sharers_after !== seen.sharers_after
                || want.range_error !== seen.range_error) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $display("%0t: mismatch want fo=%0d own=%0d wb=%0d inv=%h st=%0d sh=%h re=%0d",
                           $realtime, want.from_owner, want.owner_id, want.do_write_back,
                           want.invalidate_mask, want.next_state, want.sharers_after,
                           want.range_error);
                  $display("    got fo=%0d own=%0d wb=%0d inv=%h st=%0d sh=%h re=%0d",
                           seen.from_owner, seen.owner_id, seen.do_write_back,
                           seen.invalidate_mask, seen.next_state, seen.sharers_after,
                           seen.range_error);
               end
            end
         end
      end
   end

   // Count cycles in which neither channel moves anything; the reset sweep fits well inside.
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) begin
         stall_cycles <= 0;
      end else begin
         stall_cycles <= stall_cycles + 1;
         if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
         end
      end
   end

   initial begin
      start = 1'b0;
      reset = 1'b1;
      req_mode = MODE_READ_MISS;
      req_address = 16'd0;
      req_requester = 2'd0;
      fault_count = 0;
      idle_on = 1'b1;
      for (int i = 0; i < NUM_BLOCKS; i++) begin
         dir_state[i] = DIR_UNCACHED;
         dir_sharers[i] = 4'd0;
      end
      repeat (12) @(negedge clock);
      reset = 1'b0;

      test_read_sharing();
      test_write_ownership();
      test_invalidate();
      test_unused_mode();
      test_address_extremes();
      test_random_traffic();

      start = 1'b0;
      while (directory_outcomes.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
      fault_count += directory_outcomes.size();
      if (fault_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
